// ===== rtl/seeded_horizon_trace_picker_defines.svh =====
// Assertion macros shared by the horizon picker modules.
`ifndef SEEDED_HORIZON_TRACE_PICKER_DEFINES_SVH
`define SEEDED_HORIZON_TRACE_PICKER_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define SHTP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition.
`define SHTP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/shtp_pkg.sv =====
// Shared constants and types of the seeded horizon picker.
package shtp_pkg;

  localparam int MAX_SEEDS_DEF   = 64;
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int COORD_BITS_DEF  = 12;

  localparam int RGT_W      = 16;
  localparam int POS_W      = 10;
  localparam int STAT_W     = 3;
  localparam int HPOS_W     = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 8;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_INTERP  = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ON_SEED = 3'd1;
  localparam logic [STAT_W-1:0] STAT_CONSTR  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_SEED = 3'd3;
  localparam logic [STAT_W-1:0] STAT_STORED  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DTAU  = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/shtp_div.sv =====
// Restoring divider, one quotient bit per cycle, numerator fed MSB first.
`include "seeded_horizon_trace_picker_defines.svh"

module shtp_div #(
  parameter int NUM_W = 88,
  parameter int DEN_W = 69,
  parameter int QUO_W = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  shtp_pkg::div_ctl_t    ctl_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output shtp_pkg::div_stat_t   stat_o,
  output logic [QUO_W-1:0]      quo_o
);

  logic [NUM_W-1:0]               num_q;
  logic [DEN_W-1:0]               den_q;
  logic [DEN_W:0]                 rem_q;
  logic [QUO_W-1:0]               quo_q;
  logic [shtp_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q, done_q;

  logic [DEN_W:0] rem_sh, rem_n;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_n  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == shtp_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= {quo_q[QUO_W-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = quo_q;

  `SHTP_ASSERT_NOW(a_no_restart, clk_i, rst_ni, ctl_i.start, !busy_q,
                   "divider started while busy")
  `SHTP_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_q, !busy_q,
                   "divider done while still busy")
  `SHTP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, ctl_i.start && ctl_i.iters != '0,
                    busy_q, "divider did not start")

endmodule

// ===== rtl/seeded_horizon_trace_picker.sv =====
// Usage: seeds go in with operation 1 and are kept sorted by RGT value;
// operation 0 clears them. RGT samples of a trace go in with operation 2,
// one request per cycle while busy is low; the request marked last_sample
// starts the pick. A request is taken when start is high and busy is low.
// Each result shows on status_o/horizon_position_o for one cycle with
// done_o high; the receiver cannot hold it off. Clears and non-last
// samples give no result and leave the block idle. A seed insert reads
// each larger entry and moves it up one slot, then writes the seed. A
// pick with a constraint ends at the given position with a zero offset,
// else walks the samples toward the target. An interpolated pick does
// per seed at most one weight division of 63 quotient bits, a walk over
// the samples and at most one fraction division, then a final division
// of one bit more than the sum width; one shared radix-2 divider and one
// 32x32 multiplier do this arithmetic. Reset empties the seed table and
// the sample buffer and sets power 1 and offset 0; configuration writes
// are taken at any cycle the block is idle.
`include "seeded_horizon_trace_picker_defines.svh"

module seeded_horizon_trace_picker #(
  parameter int MAX_SEEDS   = shtp_pkg::MAX_SEEDS_DEF,
  parameter int MAX_SAMPLES = shtp_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_BITS  = shtp_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             operation_i,
  input  logic [COORD_BITS-1:0]                  trace_index_i,
  input  logic [COORD_BITS-1:0]                  inline_index_i,
  input  logic signed [shtp_pkg::RGT_W-1:0]      rgt_value_i,
  input  logic [shtp_pkg::POS_W-1:0]             position_i,
  input  logic                                   constraint_valid_i,
  input  logic                                   last_sample_i,
  input  logic                                   cfg_we_i,
  input  logic [shtp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [shtp_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic                                   done_o,
  output logic [shtp_pkg::STAT_W-1:0]            status_o,
  output logic [shtp_pkg::HPOS_W-1:0]            horizon_position_o
);

  localparam int KCW = $clog2(MAX_SEEDS + 1);
  localparam int KAW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int SCW = $clog2(MAX_SAMPLES + 1);
  localparam int SAW = $clog2(MAX_SAMPLES);
  localparam int Q8W = SAW + 8;
  localparam int D2W = 2 * COORD_BITS + 1;
  localparam int WW  = 63;
  localparam int SW  = 62 + KCW;
  localparam int SPW = SW + Q8W;
  localparam int NW  = SPW + 1;
  localparam int QW  = 64;
  localparam int PCW = (SCW > shtp_pkg::POS_W) ? SCW : shtp_pkg::POS_W;

  typedef struct packed {
    logic [COORD_BITS-1:0]             tr;
    logic [COORD_BITS-1:0]             il;
    logic signed [shtp_pkg::RGT_W-1:0] rgt;
    logic [shtp_pkg::POS_W-1:0]        pos;
  } seed_ent_t;

  typedef enum logic [21:0] {
    ST_IDLE = 22'h000001,
    ST_IRD  = 22'h000002,
    ST_ICMP = 22'h000004,
    ST_CRD0 = 22'h000008,
    ST_CTGT = 22'h000010,
    ST_CRD  = 22'h000020,
    ST_CCMP = 22'h000040,
    ST_SRD  = 22'h000080,
    ST_SDT  = 22'h000100,
    ST_SDI  = 22'h000200,
    ST_SD2  = 22'h000400,
    ST_SSQ  = 22'h000800,
    ST_WDIV = 22'h001000,
    ST_WRD  = 22'h002000,
    ST_WCMP = 22'h004000,
    ST_XIX  = 22'h008000,
    ST_XPV  = 22'h010000,
    ST_FDIV = 22'h020000,
    ST_MLO  = 22'h040000,
    ST_MHI  = 22'h080000,
    ST_MACC = 22'h100000,
    ST_FIN  = 22'h200000
  } state_e;

  // control state
  state_e                             state_q, state_d;
  logic [KCW-1:0]                     seed_cnt_q, seed_cnt_d;
  logic [SCW-1:0]                     sc_q, sc_d;
  logic                               done_q, done_d;
  logic                               pw2_q;
  logic signed [shtp_pkg::RGT_W-1:0]  dtau_q;

  // payload
  seed_ent_t                          ent_q, ent_d;
  logic [KCW-1:0]                     k_q, k_d, i_q, i_d;
  logic [SCW-1:0]                     n_q, n_d, ix_q, ix_d;
  logic [D2W-1:0]                     d2_q, d2_d;
  logic [WW-1:0]                      w_q, w_d;
  logic [SW-1:0]                      sumw_q, sumw_d;
  logic [SPW-1:0]                     sump_q, sump_d;
  logic signed [shtp_pkg::RGT_W:0]    tgt_q, tgt_d;
  logic signed [shtp_pkg::RGT_W-1:0]  six_q, six_d;
  logic [Q8W-1:0]                     q8_q, q8_d;
  logic [shtp_pkg::STAT_W-1:0]        status_q, status_d;
  logic [shtp_pkg::HPOS_W-1:0]        hpos_q, hpos_d;
  logic [63:0]                        mul_q;

  // memories
  seed_ent_t                          tab_mem [MAX_SEEDS];
  seed_ent_t                          tab_rd_q, tab_wdata;
  logic                               tab_we, tab_re;
  logic [KAW-1:0]                     tab_waddr, tab_raddr;
  logic signed [shtp_pkg::RGT_W-1:0]  samp_mem [MAX_SAMPLES];
  logic signed [shtp_pkg::RGT_W-1:0]  samp_rd_q, samp_wdata;
  logic                               samp_we, samp_re;
  logic [SAW-1:0]                     samp_waddr, samp_raddr;

  // shared units
  logic [31:0]                        mul_a, mul_b;
  shtp_pkg::div_ctl_t                 div_ctl;
  shtp_pkg::div_stat_t                div_stat;
  logic [NW-1:0]                      div_num;
  logic [SW-1:0]                      div_den;
  logic [QW-1:0]                      div_quo;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    logic [SCW-1:0]                    nnew, cix, nm1, ixm1;
    logic [PCW-1:0]                    pmin;
    logic                              cfin;
    logic [COORD_BITS-1:0]             dt_abs, di_abs;
    logic [D2W-1:0]                    d2n;
    logic [WW-1:0]                     wq;
    logic signed [shtp_pkg::RGT_W:0]   sd17, r17, sp17, num17, den17;
    logic [shtp_pkg::RGT_W:0]          an, ad;
    logic [8:0]                        frac;
    logic                              fdone;
    logic [Q8W-1:0]                    base;
    logic [SPW-1:0]                    sump_n;
    logic [QW-1:0]                     lim, res;

    state_d    = state_q;
    seed_cnt_d = seed_cnt_q;
    sc_d       = sc_q;
    done_d     = 1'b0;
    ent_d      = ent_q;
    k_d        = k_q;
    i_d        = i_q;
    n_d        = n_q;
    ix_d       = ix_q;
    d2_d       = d2_q;
    w_d        = w_q;
    sumw_d     = sumw_q;
    sump_d     = sump_q;
    tgt_d      = tgt_q;
    six_d      = six_q;
    q8_d       = q8_q;
    status_d   = status_q;
    hpos_d     = hpos_q;

    tab_we     = 1'b0;
    tab_re     = 1'b0;
    tab_waddr  = k_q[KAW-1:0];
    tab_raddr  = i_q[KAW-1:0];
    tab_wdata  = ent_q;
    samp_we    = 1'b0;
    samp_re    = 1'b0;
    samp_waddr = sc_q[SAW-1:0];
    samp_raddr = ix_q[SAW-1:0];
    samp_wdata = rgt_value_i;
    mul_a      = '0;
    mul_b      = '0;
    div_ctl    = '0;
    div_num    = '0;
    div_den    = '0;

    nm1    = n_q - 1'b1;
    ixm1   = ix_q - 1'b1;
    nnew   = sc_q;
    cix    = ix_q;
    cfin   = 1'b0;
    pmin   = '0;
    dt_abs = (ent_q.tr >= tab_rd_q.tr) ? ent_q.tr - tab_rd_q.tr : tab_rd_q.tr - ent_q.tr;
    di_abs = (ent_q.il >= tab_rd_q.il) ? ent_q.il - tab_rd_q.il : tab_rd_q.il - ent_q.il;
    d2n    = d2_q + D2W'(mul_q);
    wq     = div_quo[WW-1:0];
    sd17   = {samp_rd_q[shtp_pkg::RGT_W-1], samp_rd_q};
    r17    = {tab_rd_q.rgt[shtp_pkg::RGT_W-1], tab_rd_q.rgt};
    sp17   = sd17;
    num17  = r17 - sp17;
    den17  = {six_q[shtp_pkg::RGT_W-1], six_q} - sp17;
    an     = num17[shtp_pkg::RGT_W] ? -num17 : num17;
    ad     = den17[shtp_pkg::RGT_W] ? -den17 : den17;
    frac   = '0;
    fdone  = 1'b1;
    base   = {ixm1[SAW-1:0], 8'd0};
    sump_n = sump_q + (SPW'(mul_q) << 32);
    lim    = QW'({nm1, 8'd0});
    res    = (div_quo > lim) ? lim : div_quo;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ent_d = '{tr: trace_index_i, il: inline_index_i, rgt: rgt_value_i,
                    pos: position_i};
          case (operation_i)
            shtp_pkg::OP_CLEAR: seed_cnt_d = '0;
            shtp_pkg::OP_INSERT: begin
              if (seed_cnt_q >= KCW'(MAX_SEEDS)) begin
                done_d   = 1'b1;
                status_d = shtp_pkg::STAT_FULL;
                hpos_d   = '0;
              end else begin
                k_d     = seed_cnt_q;
                state_d = ST_IRD;
              end
            end
            shtp_pkg::OP_SAMPLE: begin
              if (sc_q < SCW'(MAX_SAMPLES)) begin
                samp_we = 1'b1;
                nnew    = sc_q + 1'b1;
              end
              sc_d = nnew;
              if (last_sample_i) begin
                sc_d = '0;
                n_d  = nnew;
                if (constraint_valid_i) begin
                  state_d = ST_CRD0;
                end else if (seed_cnt_q == '0) begin
                  done_d   = 1'b1;
                  status_d = shtp_pkg::STAT_NO_SEED;
                  hpos_d   = '0;
                end else begin
                  i_d     = '0;
                  ix_d    = '0;
                  sumw_d  = '0;
                  sump_d  = '0;
                  state_d = ST_SRD;
                end
              end
            end
            default: ;
          endcase
        end
      end

      // shift larger entries up one slot until the new seed fits
      ST_IRD: begin
        if (k_q == '0) begin
          tab_we     = 1'b1;
          seed_cnt_d = seed_cnt_q + 1'b1;
          done_d     = 1'b1;
          status_d   = shtp_pkg::STAT_STORED;
          hpos_d     = '0;
          state_d    = ST_IDLE;
        end else begin
          tab_re    = 1'b1;
          tab_raddr = KAW'(k_q - 1'b1);
          state_d   = ST_ICMP;
        end
      end
      ST_ICMP: begin
        tab_we = 1'b1;
        if ($signed(tab_rd_q.rgt) > $signed(ent_q.rgt)) begin
          tab_wdata = tab_rd_q;
          k_d       = k_q - 1'b1;
          state_d   = ST_IRD;
        end else begin
          seed_cnt_d = seed_cnt_q + 1'b1;
          done_d     = 1'b1;
          status_d   = shtp_pkg::STAT_STORED;
          hpos_d     = '0;
          state_d    = ST_IDLE;
        end
      end

      // constraint walk
      ST_CRD0: begin
        pmin       = (PCW'(ent_q.pos) < PCW'(nm1)) ? PCW'(ent_q.pos) : PCW'(nm1);
        ix_d       = SCW'(pmin);
        samp_re    = 1'b1;
        samp_raddr = SAW'(pmin);
        state_d    = ST_CTGT;
      end
      ST_CTGT: begin
        tgt_d = sd17 + {dtau_q[shtp_pkg::RGT_W-1], dtau_q};
        if (dtau_q == '0) begin
          cfin = 1'b1;
        end else begin
          state_d = ST_CCMP;
        end
      end
      ST_CRD: begin
        samp_re = 1'b1;
        state_d = ST_CCMP;
      end
      ST_CCMP: begin
        if (!dtau_q[shtp_pkg::RGT_W-1]) begin
          if (sd17 < tgt_q) begin
            if (ix_q + 1'b1 == n_q) begin
              cfin = 1'b1;
            end else begin
              ix_d    = ix_q + 1'b1;
              state_d = ST_CRD;
            end
          end else begin
            cfin = 1'b1;
          end
        end else begin
          if (sd17 > tgt_q) begin
            if (ix_q == '0) begin
              cfin = 1'b1;
            end else begin
              ix_d    = ixm1;
              state_d = ST_CRD;
            end
          end else begin
            cfin = 1'b1;
            if (ix_q < nm1 && sd17 < tgt_q) cix = ix_q + 1'b1;
          end
        end
      end

      // per seed: distance, weight, crossing, accumulate
      ST_SRD: begin
        tab_re  = 1'b1;
        state_d = ST_SDT;
      end
      ST_SDT: begin
        mul_a   = 32'(dt_abs);
        mul_b   = 32'(dt_abs);
        state_d = ST_SDI;
      end
      ST_SDI: begin
        d2_d    = D2W'(mul_q);
        mul_a   = 32'(di_abs);
        mul_b   = 32'(di_abs);
        state_d = ST_SD2;
      end
      ST_SD2: begin
        d2_d = d2n;
        if (d2n == '0) begin
          pmin     = (PCW'(tab_rd_q.pos) < PCW'(nm1)) ? PCW'(tab_rd_q.pos) : PCW'(nm1);
          done_d   = 1'b1;
          status_d = shtp_pkg::STAT_ON_SEED;
          hpos_d   = shtp_pkg::HPOS_W'({pmin, 8'd0});
          state_d  = ST_IDLE;
        end else if (pw2_q && (34'(d2n) > 34'h0_8000_0000)) begin
          w_d     = WW'(1);
          sumw_d  = sumw_q + SW'(1);
          state_d = ST_WRD;
        end else if (pw2_q) begin
          mul_a   = 32'(d2n);
          mul_b   = 32'(d2n);
          state_d = ST_SSQ;
        end else begin
          div_ctl.start = 1'b1;
          div_ctl.iters = shtp_pkg::DIV_CNT_W'(WW);
          div_num       = NW'(1) << (NW - 1);
          div_den       = SW'(d2n);
          state_d       = ST_WDIV;
        end
      end
      ST_SSQ: begin
        div_ctl.start = 1'b1;
        div_ctl.iters = shtp_pkg::DIV_CNT_W'(WW);
        div_num       = NW'(1) << (NW - 1);
        div_den       = SW'(mul_q);
        state_d       = ST_WDIV;
      end
      ST_WDIV: begin
        if (div_stat.done) begin
          w_d     = (wq == '0) ? WW'(1) : wq;
          sumw_d  = sumw_q + SW'((wq == '0) ? WW'(1) : wq);
          state_d = ST_WRD;
        end
      end
      ST_WRD: begin
        samp_re = 1'b1;
        if (ix_q < n_q) begin
          state_d = ST_WCMP;
        end else begin
          ix_d       = nm1;
          samp_raddr = nm1[SAW-1:0];
          state_d    = ST_XIX;
        end
      end
      ST_WCMP: begin
        if (sd17 < r17) begin
          ix_d    = ix_q + 1'b1;
          state_d = ST_WRD;
        end else begin
          state_d = ST_XIX;
        end
      end
      ST_XIX: begin
        six_d = samp_rd_q;
        if (sd17 == r17 || ix_q == '0) begin
          q8_d    = {ix_q[SAW-1:0], 8'd0};
          state_d = ST_MLO;
        end else begin
          samp_re    = 1'b1;
          samp_raddr = ixm1[SAW-1:0];
          state_d    = ST_XPV;
        end
      end
      ST_XPV: begin
        if (den17 == '0) begin
          frac = (num17 > 0) ? 9'd256 : 9'd0;
        end else if (num17 == '0 || (num17 > 0 && den17 < 0) ||
                     (num17 < 0 && den17 > 0)) begin
          frac = 9'd0;
        end else if (an >= ad) begin
          frac = 9'd256;
        end else begin
          fdone         = 1'b0;
          div_ctl.start = 1'b1;
          div_ctl.iters = shtp_pkg::DIV_CNT_W'(shtp_pkg::RGT_W + 9);
          div_num       = NW'({an, 8'd0}) << (NW - (shtp_pkg::RGT_W + 9));
          div_den       = SW'(ad);
          state_d       = ST_FDIV;
        end
        if (fdone) begin
          q8_d    = base + Q8W'(frac);
          state_d = ST_MLO;
        end
      end
      ST_FDIV: begin
        if (div_stat.done) begin
          q8_d    = base + Q8W'(div_quo[7:0]);
          state_d = ST_MLO;
        end
      end
      ST_MLO: begin
        mul_a   = 32'(q8_q);
        mul_b   = w_q[31:0];
        state_d = ST_MHI;
      end
      ST_MHI: begin
        sump_d  = sump_q + SPW'(mul_q);
        mul_a   = 32'(q8_q);
        mul_b   = 32'(w_q[WW-1:32]);
        state_d = ST_MACC;
      end
      ST_MACC: begin
        sump_d = sump_n;
        i_d    = i_q + 1'b1;
        if (i_q + 1'b1 == seed_cnt_q) begin
          div_ctl.start = 1'b1;
          div_ctl.iters = shtp_pkg::DIV_CNT_W'(NW);
          div_num       = NW'(sump_n) + NW'(sumw_q >> 1);
          div_den       = sumw_q;
          state_d       = ST_FIN;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_FIN: begin
        if (div_stat.done) begin
          done_d   = 1'b1;
          status_d = shtp_pkg::STAT_INTERP;
          hpos_d   = res[shtp_pkg::HPOS_W-1:0];
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfin) begin
      done_d   = 1'b1;
      status_d = shtp_pkg::STAT_CONSTR;
      hpos_d   = (state_q == ST_CCMP && dtau_q[shtp_pkg::RGT_W-1] && sd17 > tgt_q)
                 ? '0 : shtp_pkg::HPOS_W'({cix, 8'd0});
      state_d  = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      seed_cnt_q <= '0;
      sc_q       <= '0;
      done_q     <= 1'b0;
      pw2_q      <= 1'b0;
      dtau_q     <= '0;
    end else begin
      state_q    <= state_d;
      seed_cnt_q <= seed_cnt_d;
      sc_q       <= sc_d;
      done_q     <= done_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          shtp_pkg::CFG_POWER: pw2_q  <= cfg_wdata_i[1];
          shtp_pkg::CFG_DTAU:  dtau_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q    <= ent_d;
    k_q      <= k_d;
    i_q      <= i_d;
    n_q      <= n_d;
    ix_q     <= ix_d;
    d2_q     <= d2_d;
    w_q      <= w_d;
    sumw_q   <= sumw_d;
    sump_q   <= sump_d;
    tgt_q    <= tgt_d;
    six_q    <= six_d;
    q8_q     <= q8_d;
    status_q <= status_d;
    hpos_q   <= hpos_d;
    mul_q    <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    if (tab_re) tab_rd_q <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (samp_we) samp_mem[samp_waddr] <= samp_wdata;
    if (samp_re) samp_rd_q <= samp_mem[samp_raddr];
  end

  shtp_div #(
    .NUM_W (NW),
    .DEN_W (SW),
    .QUO_W (QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo)
  );

  assign done_o             = done_q;
  assign status_o           = status_q;
  assign horizon_position_o = hpos_q;

  `SHTP_ASSERT_NOW(a_done_in_idle, clk_i, rst_ni, done_q, state_q == ST_IDLE,
                   "result shown while still working")
  `SHTP_ASSERT_NOW(a_seed_res_zero, clk_i, rst_ni,
                   done_q && (status_q == shtp_pkg::STAT_STORED ||
                              status_q == shtp_pkg::STAT_FULL),
                   hpos_q == '0, "seed result carries a position")
  `SHTP_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, seed_cnt_q <= KCW'(MAX_SEEDS),
                   "seed count beyond table size")
  `SHTP_ASSERT_NEXT(a_full_drop, clk_i, rst_ni,
                    start && !busy && operation_i == shtp_pkg::OP_INSERT &&
                    seed_cnt_q == KCW'(MAX_SEEDS),
                    done_q && status_q == shtp_pkg::STAT_FULL,
                    "insert into full table not reported")

endmodule
